// ===== design/ahe_pkg.sv =====
// ----------------------------------------------------------------------------
// ahe_pkg
// Shared types and constants for the ASCII-hex frame encoder.
// ----------------------------------------------------------------------------
package ahe_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_POLL_TYPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_USER_TYPE = 1'b1;

  localparam logic [BYTE_W-1:0] POLL_TYPE_RESET = 8'h00;
  localparam logic [BYTE_W-1:0] USER_TYPE_RESET = 8'h01;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_DATA   = 1'b1;

  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3a;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_A_OFS = 8'h37;  // 'A' - 10

  // Frame segments, in emission order.
  localparam int SEG_COLON = 0;
  localparam int SEG_HD    = 1;
  localparam int SEG_HS    = 2;
  localparam int SEG_TY    = 3;
  localparam int SEG_SN    = 4;
  localparam int SEG_DN    = 5;
  localparam int SEG_LN    = 6;
  localparam int SEG_DB    = 7;
  localparam int SEG_SUM   = 8;
  localparam int SEG_CR    = 9;
  localparam int SEG_LF    = 10;
  localparam int SEG_N     = 11;
  localparam int SEG_W     = $clog2(SEG_N);

  typedef logic [SEG_N-1:0] seg_mask_t;

  typedef struct packed {
    seg_mask_t         mask;
    logic [BYTE_W-1:0] hd;
    logic [BYTE_W-1:0] hs;
    logic [BYTE_W-1:0] ty;
    logic [BYTE_W-1:0] sn;
    logic [BYTE_W-1:0] dn;
    logic [BYTE_W-1:0] ln;
    logic [BYTE_W-1:0] db;
    logic [BYTE_W-1:0] sum;
  } op_t;

  function automatic logic [BYTE_W-1:0] nibble_char(input logic [3:0] v);
    logic [BYTE_W-1:0] ext;
    ext = {4'h0, v};
    return (v > 4'd9) ? ext + CHAR_A_OFS : ext + CHAR_ZERO;
  endfunction

endpackage

// ===== design/ahe_front.sv =====
// ----------------------------------------------------------------------------
// ahe_front
// Accepts header and data items, tracks frame state and checksum, and
// issues one character-group operation per item that produces output.
// ----------------------------------------------------------------------------
module ahe_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ahe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ahe_pkg::BYTE_W-1:0]        cfg_data,
  input  logic                              accept,
  input  logic                              command,
  input  logic [ahe_pkg::BYTE_W-1:0]        hw_dest,
  input  logic [ahe_pkg::BYTE_W-1:0]        hw_src,
  input  logic [ahe_pkg::BYTE_W-1:0]        msg_type,
  input  logic [ahe_pkg::BYTE_W-1:0]        src_node,
  input  logic [ahe_pkg::BYTE_W-1:0]        dest_node,
  input  logic [ahe_pkg::BYTE_W-1:0]        data_length,
  input  logic [ahe_pkg::BYTE_W-1:0]        data_byte,
  output logic                              push,
  output ahe_pkg::op_t                      op
);
  import ahe_pkg::*;

  logic [BYTE_W-1:0] poll_code;
  logic [BYTE_W-1:0] user_code;
  logic              awaiting_data, awaiting_data_next;
  logic [BYTE_W-1:0] bytes_left, bytes_left_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic              send_data, send_data_next;

  logic              is_poll, is_user, trailer;
  logic [BYTE_W-1:0] left_dec;
  seg_mask_t         mask;

  always_comb begin
    is_poll            = (msg_type == poll_code);
    is_user            = !is_poll && (msg_type == user_code);
    left_dec           = bytes_left - 8'd1;
    mask               = '0;
    trailer            = 1'b0;
    push               = 1'b0;
    awaiting_data_next = awaiting_data;
    bytes_left_next    = bytes_left;
    running_sum_next   = running_sum;
    send_data_next     = send_data;
    if (command == CMD_HEADER) begin
      running_sum_next = hw_dest + hw_src;
      if (!is_poll) begin
        running_sum_next = running_sum_next + msg_type + src_node + dest_node + data_length;
      end
      mask[SEG_COLON] = 1'b1;
      mask[SEG_HD]    = 1'b1;
      mask[SEG_HS]    = 1'b1;
      mask[SEG_TY]    = 1'b1;
      mask[SEG_SN]    = is_user;
      mask[SEG_DN]    = is_user;
      mask[SEG_LN]    = is_user;
      trailer         = is_poll || (data_length == '0);
      push            = accept;
      if (!trailer) begin
        awaiting_data_next = 1'b1;
        bytes_left_next    = data_length;
        send_data_next     = is_user;
      end
    end else if (awaiting_data) begin
      running_sum_next = running_sum + data_byte;
      mask[SEG_DB]     = send_data;
      trailer          = (left_dec == '0);
      bytes_left_next  = left_dec;
      push             = accept && (send_data || trailer);
    end
    if (trailer) begin
      mask[SEG_SUM]      = 1'b1;
      mask[SEG_CR]       = 1'b1;
      mask[SEG_LF]       = 1'b1;
      awaiting_data_next = 1'b0;
      bytes_left_next    = '0;
      send_data_next     = 1'b0;
    end
    op.mask = mask;
    op.hd   = hw_dest;
    op.hs   = hw_src;
    op.ty   = msg_type;
    op.sn   = src_node;
    op.dn   = dest_node;
    op.ln   = data_length;
    op.db   = data_byte;
    op.sum  = running_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_code     <= POLL_TYPE_RESET;
      user_code     <= USER_TYPE_RESET;
      awaiting_data <= 1'b0;
      bytes_left    <= '0;
      running_sum   <= '0;
      send_data     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POLL_TYPE: poll_code <= cfg_data;
          REG_USER_TYPE: user_code <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        awaiting_data <= awaiting_data_next;
        bytes_left    <= bytes_left_next;
        running_sum   <= running_sum_next;
        send_data     <= send_data_next;
      end
    end
  end

endmodule

// ===== design/ahe_queue.sv =====
// ----------------------------------------------------------------------------
// ahe_queue
// Small FIFO of operations between the front and back parts.
// ----------------------------------------------------------------------------
module ahe_queue #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  ahe_pkg::op_t push_data,
  output logic         push_ready,
  input  logic         pop,
  output logic         pop_valid,
  output ahe_pkg::op_t pop_data
);
  import ahe_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  op_t           mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/ahe_back.sv =====
// ----------------------------------------------------------------------------
// ahe_back
// Walks the segments of one operation and emits one frame character per
// cycle into the output register while out_ready does not stall it.
// ----------------------------------------------------------------------------
module ahe_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  ahe_pkg::op_t               q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ahe_pkg::BYTE_W-1:0] out_char,
  output logic                       last_char,
  output logic [ahe_pkg::BYTE_W-1:0] checksum
);
  import ahe_pkg::*;

  op_t               cur;
  seg_mask_t         cur_mask;
  logic              cur_lo;

  logic [SEG_W-1:0]  seg;
  seg_mask_t         seg_bit;
  seg_mask_t         rest_mask;
  logic              is_pair, seg_done, op_done, busy, advance;
  logic [BYTE_W-1:0] sel_byte, char_next;

  always_comb begin
    seg     = '0;
    seg_bit = '0;
    for (int i = SEG_N - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        seg     = SEG_W'(i);
        seg_bit = seg_mask_t'(1) << i;
      end
    end
    case (seg)
      SEG_W'(SEG_HD):  sel_byte = cur.hd;
      SEG_W'(SEG_HS):  sel_byte = cur.hs;
      SEG_W'(SEG_TY):  sel_byte = cur.ty;
      SEG_W'(SEG_SN):  sel_byte = cur.sn;
      SEG_W'(SEG_DN):  sel_byte = cur.dn;
      SEG_W'(SEG_LN):  sel_byte = cur.ln;
      SEG_W'(SEG_DB):  sel_byte = cur.db;
      default:         sel_byte = cur.sum;
    endcase
    case (seg)
      SEG_W'(SEG_COLON): char_next = CHAR_COLON;
      SEG_W'(SEG_CR):    char_next = CHAR_CR;
      SEG_W'(SEG_LF):    char_next = CHAR_LF;
      default:           char_next = nibble_char(cur_lo ? sel_byte[3:0] : sel_byte[7:4]);
    endcase
    is_pair   = (seg >= SEG_W'(SEG_HD)) && (seg <= SEG_W'(SEG_SUM));
    seg_done  = !is_pair || cur_lo;
    rest_mask = cur_mask & ~seg_bit;
    op_done   = seg_done && (rest_mask == '0);
    busy      = (cur_mask != '0);
    advance   = busy && (!out_valid || out_ready);
    q_pop     = q_valid && (!busy || (advance && op_done));
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (advance) begin
      out_char  <= char_next;
      last_char <= (seg == SEG_W'(SEG_LF));
      checksum  <= cur.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask  <= '0;
      cur_lo    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_mask <= q_data.mask;
        cur_lo   <= 1'b0;
      end else if (advance) begin
        if (seg_done) begin
          cur_mask <= rest_mask;
          cur_lo   <= 1'b0;
        end else begin
          cur_lo   <= 1'b1;
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/ascii_hex_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_frame_encoder
// ASCII-hex frame builder with additive 8-bit checksum: ':' start, hex
// pairs for header fields and data, checksum pair, CR, LF.
// ----------------------------------------------------------------------------
// Items pass the queue and operation register to the output register.
// Throughput: one character per cycle from the back part unless out_ready
//   stalls it; a sent data byte gives 2 characters, a header 7 to 17.
// Reset: synchronous; clears frame state, queue and output; type codes
//   return to poll 0 and user 1.
module ascii_hex_frame_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ahe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ahe_pkg::BYTE_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [ahe_pkg::BYTE_W-1:0]        hw_dest,
  input  logic [ahe_pkg::BYTE_W-1:0]        hw_src,
  input  logic [ahe_pkg::BYTE_W-1:0]        msg_type,
  input  logic [ahe_pkg::BYTE_W-1:0]        src_node,
  input  logic [ahe_pkg::BYTE_W-1:0]        dest_node,
  input  logic [ahe_pkg::BYTE_W-1:0]        data_length,
  input  logic [ahe_pkg::BYTE_W-1:0]        data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ahe_pkg::BYTE_W-1:0]        out_char,
  output logic                              last_char,
  output logic [ahe_pkg::BYTE_W-1:0]        checksum
);
  import ahe_pkg::*;

  logic accept;
  logic q_push, q_push_ready, q_pop, q_valid;
  op_t  q_in, q_out;

  assign in_ready = q_push_ready;
  assign accept   = in_valid && in_ready;

  ahe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .command     (command),
    .hw_dest     (hw_dest),
    .hw_src      (hw_src),
    .msg_type    (msg_type),
    .src_node    (src_node),
    .dest_node   (dest_node),
    .data_length (data_length),
    .data_byte   (data_byte),
    .push        (q_push),
    .op          (q_in)
  );

  ahe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out)
  );

  ahe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last_char (last_char),
    .checksum  (checksum)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_push_ready)
    else $error("operation pushed into full queue");

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_last_is_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_char |-> out_char == CHAR_LF)
    else $error("frame end flag on a character other than LF");

  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

// ===== tb/ascii_hex_frame_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_frame_encoder_tb
// Self-checking bench for the ASCII-hex frame encoder. A queue of header,
// data, register-write, drain and calm-mode operations feeds a clocked driver. Each
// accepted transfer runs through a behavioral encoder that queues the
// expected characters. A clocked monitor checks every output transfer,
// field by field, against the oldest queued character. Both sides stall
// at random, apart from one stretch with no stalls.
// ----------------------------------------------------------------------------
module ascii_hex_frame_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ahe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          SETTLE      = 8;
  localparam int          ITEM_TARGET = 470;

  typedef enum {OP_ITEM, OP_CFG, OP_DRAIN, OP_CALM} enc_kind_t;

  typedef struct {
    enc_kind_t              kind;
    logic                   cmd;
    logic [BYTE_W-1:0]      hd, hs, ty, sn, dn, ln, db;
    logic [CFG_IDX_W-1:0]   idx;
    logic [BYTE_W-1:0]      val;
  } enc_op_t;

  typedef struct {
    logic [BYTE_W-1:0] ch;
    logic              last;
    logic [BYTE_W-1:0] sum;
  } frame_char_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 command = CMD_HEADER;
  logic [BYTE_W-1:0]    hw_dest = '0;
  logic [BYTE_W-1:0]    hw_src = '0;
  logic [BYTE_W-1:0]    msg_type = '0;
  logic [BYTE_W-1:0]    src_node = '0;
  logic [BYTE_W-1:0]    dest_node = '0;
  logic [BYTE_W-1:0]    data_length = '0;
  logic [BYTE_W-1:0]    data_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    out_char;
  logic                 last_char;
  logic [BYTE_W-1:0]    checksum;

  enc_op_t     encoder_ops[$];
  frame_char_t frame_chars[$];

  // behavioral encoder state
  logic [BYTE_W-1:0] enc_poll_code = POLL_TYPE_RESET;
  logic [BYTE_W-1:0] enc_user_code = USER_TYPE_RESET;
  logic              enc_open = 1'b0;
  logic [BYTE_W-1:0] enc_left = '0;
  logic [BYTE_W-1:0] enc_sum = '0;
  logic              enc_hex_data = 1'b0;

  // codes in force while the stimulus is built
  logic [BYTE_W-1:0] plan_poll = POLL_TYPE_RESET;
  logic [BYTE_W-1:0] plan_user = USER_TYPE_RESET;

  logic        calm = 1'b0;
  int          quiet = 0;
  int unsigned cycle_count = 0;
  int          errors = 0;
  int          planned_items = 0;
  int          transfers_in = 0;
  int          chars_checked = 0;
  int          frames_closed = 0;
  int          cfg_writes = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  ascii_hex_frame_encoder DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .hw_dest(hw_dest), .hw_src(hw_src), .msg_type(msg_type),
    .src_node(src_node), .dest_node(dest_node), .data_length(data_length),
    .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_char(out_char), .last_char(last_char), .checksum(checksum)
  );

  // ---------------- expected character generation ----------------

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) return 8'h30 + wide;
    return 8'h41 + wide - 8'd10;
  endfunction

  function automatic void push_char(input logic [BYTE_W-1:0] c, input logic last);
    frame_char_t fc;
    fc.ch = c;
    fc.last = last;
    fc.sum = enc_sum;
    frame_chars.push_back(fc);
  endfunction

  function automatic void push_hex(input logic [BYTE_W-1:0] b);
    push_char(hex_digit(b[7:4]), 1'b0);
    push_char(hex_digit(b[3:0]), 1'b0);
  endfunction

  function automatic void push_trailer();
    push_hex(enc_sum);
    push_char(CHAR_CR, 1'b0);
    push_char(CHAR_LF, 1'b1);
    enc_open = 1'b0;
    enc_left = '0;
    enc_hex_data = 1'b0;
  endfunction

  function automatic void encode_item(input enc_op_t it);
    logic is_poll, is_user;
    if (it.cmd == CMD_HEADER) begin
      is_poll = (it.ty == enc_poll_code);
      is_user = !is_poll && (it.ty == enc_user_code);
      enc_sum = it.hd + it.hs;
      if (!is_poll) enc_sum = enc_sum + it.ty + it.sn + it.dn + it.ln;
      push_char(CHAR_COLON, 1'b0);
      push_hex(it.hd);
      push_hex(it.hs);
      push_hex(it.ty);
      if (is_user) begin
        push_hex(it.sn);
        push_hex(it.dn);
        push_hex(it.ln);
      end
      if (is_poll || it.ln == 8'd0) begin
        push_trailer();
      end else begin
        enc_open = 1'b1;
        enc_left = it.ln;
        enc_hex_data = is_user;
      end
    end else if (enc_open) begin
      enc_sum = enc_sum + it.db;
      if (enc_hex_data) push_hex(it.db);
      enc_left = enc_left - 8'd1;
      if (enc_left == 8'd0) push_trailer();
    end
  endfunction

  // ---------------- driver ----------------

  always @(posedge clk) begin : drive_proc
    logic    nv;
    logic    cwe;
    enc_op_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_we <= 1'b0;
      quiet <= 0;
    end else begin
      nv = in_valid;
      cwe = 1'b0;
      if (in_valid && in_ready) begin
        nxt.kind = OP_ITEM;
        nxt.cmd = command;
        nxt.hd = hw_dest;
        nxt.hs = hw_src;
        nxt.ty = msg_type;
        nxt.sn = src_node;
        nxt.dn = dest_node;
        nxt.ln = data_length;
        nxt.db = data_byte;
        encode_item(nxt);
        transfers_in++;
        nv = 1'b0;
      end
      if (!nv && encoder_ops.size() != 0) begin
        nxt = encoder_ops[0];
        case (nxt.kind)
          OP_ITEM: begin
            if (calm || $urandom_range(99) >= 21) begin
              command <= nxt.cmd;
              hw_dest <= nxt.hd;
              hw_src <= nxt.hs;
              msg_type <= nxt.ty;
              src_node <= nxt.sn;
              dest_node <= nxt.dn;
              data_length <= nxt.ln;
              data_byte <= nxt.db;
              nv = 1'b1;
              void'(encoder_ops.pop_front());
            end
          end
          OP_CFG: begin
            if (quiet >= SETTLE) begin
              cwe = 1'b1;
              cfg_index <= nxt.idx;
              cfg_data <= nxt.val;
              if (nxt.idx == REG_POLL_TYPE) enc_poll_code = nxt.val;
              else enc_user_code = nxt.val;
              cfg_writes++;
              void'(encoder_ops.pop_front());
            end
          end
          OP_DRAIN: begin
            if (quiet >= SETTLE) void'(encoder_ops.pop_front());
          end
          OP_CALM: begin
            calm <= nxt.val[0];
            void'(encoder_ops.pop_front());
          end
          default: ;
        endcase
      end
      in_valid <= nv;
      cfg_we <= cwe;
      quiet <= (nv || in_valid || frame_chars.size() != 0) ? 0 : quiet + 1;
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin : watch_proc
    frame_char_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_chars.size() == 0) begin
          $error("unexpected transfer: out_char %h last_char %b checksum %h",
                 out_char, last_char, checksum);
          errors++;
        end else begin
          want = frame_chars.pop_front();
          chars_checked++;
          if (out_char !== want.ch) begin
            $error("out_char: expected %h, actual %h", want.ch, out_char);
            errors++;
          end
          if (last_char !== want.last) begin
            $error("last_char: expected %b, actual %b", want.last, last_char);
            errors++;
          end
          if (checksum !== want.sum) begin
            $error("checksum: expected %h, actual %h", want.sum, checksum);
            errors++;
          end
          if (want.last) frames_closed++;
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 21);
    end
  end

  // ---------------- stimulus planning ----------------

  function automatic logic [BYTE_W-1:0] rnd8();
    return BYTE_W'($urandom_range(255));
  endfunction

  task automatic add_item(input logic cmd, input logic [BYTE_W-1:0] hd, hs, ty, sn,
                          dn, ln, db, input bit counted = 1'b1);
    enc_op_t op;
    op.kind = OP_ITEM;
    op.cmd = cmd;
    op.hd = hd;
    op.hs = hs;
    op.ty = ty;
    op.sn = sn;
    op.dn = dn;
    op.ln = ln;
    op.db = db;
    op.idx = '0;
    op.val = '0;
    encoder_ops.push_back(op);
    if (counted) planned_items++;
  endtask

  task automatic add_header(input logic [BYTE_W-1:0] ty, ln);
    add_item(CMD_HEADER, rnd8(), rnd8(), ty, rnd8(), rnd8(), ln, rnd8());
  endtask

  task automatic add_data(input logic [BYTE_W-1:0] db, input bit counted = 1'b1);
    add_item(CMD_DATA, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), db, counted);
  endtask

  task automatic add_ctrl(input enc_kind_t kind, input logic [CFG_IDX_W-1:0] idx,
                          input logic [BYTE_W-1:0] val);
    enc_op_t op;
    op.kind = kind;
    op.cmd = CMD_HEADER;
    op.hd = '0;
    op.hs = '0;
    op.ty = '0;
    op.sn = '0;
    op.dn = '0;
    op.ln = '0;
    op.db = '0;
    op.idx = idx;
    op.val = val;
    encoder_ops.push_back(op);
    if (kind == OP_CFG) begin
      if (idx == REG_POLL_TYPE) plan_poll = val;
      else plan_user = val;
    end
  endtask

  task automatic add_codes(input logic [BYTE_W-1:0] poll, user);
    add_ctrl(OP_DRAIN, '0, '0);
    add_ctrl(OP_CFG, REG_POLL_TYPE, poll);
    add_ctrl(OP_CFG, REG_USER_TYPE, user);
  endtask

  function automatic logic [BYTE_W-1:0] other_type();
    logic [BYTE_W-1:0] t;
    do t = rnd8(); while (t == plan_poll || t == plan_user);
    return t;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 70) return BYTE_W'($urandom_range(4));
    if (r < 95) return BYTE_W'($urandom_range(16, 5));
    return BYTE_W'($urandom_range(40, 17));
  endfunction

  task automatic add_random_frame();
    int r, cls, n;
    logic [BYTE_W-1:0] ty, ln;
    r = $urandom_range(99);
    if (r < 8) begin
      add_data(rnd8(), 1'b0);
      return;
    end
    if (r < 18) begin
      // abandoned frame, closed off by a fresh header
      ln = BYTE_W'($urandom_range(255, 2));
      add_header(($urandom_range(1) != 0) ? plan_user : other_type(), ln);
      n = $urandom_range((ln > 5) ? 4 : ln - 1);
      repeat (n) add_data(rnd8());
    end
    cls = $urandom_range(99);
    if (cls < 40) ty = plan_user;
    else if (cls < 65) ty = plan_poll;
    else if (cls < 90) ty = other_type();
    else ty = rnd8();
    if (ty == plan_poll) begin
      add_header(ty, rnd8());
    end else begin
      ln = pick_length();
      add_header(ty, ln);
      repeat (ln) add_data(rnd8());
    end
  endtask

  initial begin : main_proc
    int phase;
    int phase_start;

    // zero-length user frame: header alone makes the whole frame
    add_item(CMD_HEADER, 8'hFF, 8'h00, USER_TYPE_RESET, 8'hA5, 8'h5A, 8'h00, 8'hFF);
    // poll ignores its length field
    add_item(CMD_HEADER, 8'hFF, 8'hFF, POLL_TYPE_RESET, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    // stray data, no frame open
    add_item(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
    add_item(CMD_HEADER, 8'h00, 8'hFF, USER_TYPE_RESET, 8'h00, 8'hFF, 8'h02, 8'h00);
    add_data(8'h00);
    add_data(8'hFF);
    // other type: data summed, not sent
    add_item(CMD_HEADER, 8'h12, 8'h34, 8'h80, 8'h56, 8'h78, 8'h03, 8'h9A);
    add_data(8'hFF);
    add_data(8'h80);
    add_data(8'h7F);
    // header while data is still due
    add_header(USER_TYPE_RESET, 8'h05);
    add_data(8'hC3);
    add_header(8'hFE, 8'h00);
    add_item(CMD_HEADER, 8'h00, 8'hFF, USER_TYPE_RESET, 8'hFF, 8'h00, 8'h01, 8'h00);
    add_data(8'h5A);
    // equal codes: poll wins
    add_codes(8'h55, 8'h55);
    add_header(8'h55, 8'h03);
    add_codes(8'hFF, 8'h00);
    add_header(8'h00, 8'h01);
    add_data(8'hE7);
    add_header(8'hFF, 8'h20);
    add_header(8'h01, 8'h01);
    add_data(8'h3C);

    phase = 0;
    while (planned_items < ITEM_TARGET) begin
      case (phase)
        0: add_codes(8'h00, 8'hFF);
        1: begin
          add_codes(8'hFF, 8'h00);
          add_ctrl(OP_CALM, '0, 8'h01);
        end
        2: begin
          add_ctrl(OP_CALM, '0, 8'h00);
          add_codes(8'hA0, 8'hA0);
        end
        default: add_codes(rnd8(), rnd8());
      endcase
      phase_start = planned_items;
      while (planned_items - phase_start < 75 && planned_items < ITEM_TARGET)
        add_random_frame();
      phase++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while ((encoder_ops.size() != 0 || in_valid || frame_chars.size() != 0) &&
           cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d characters still due",
             cycle_count, frame_chars.size());
      errors++;
    end
    $display("Covered %0d input transfers, %0d frames, %0d characters checked,",
             transfers_in, frames_closed, chars_checked);
    $display("with %0d type-code writes across %0d random phases.", cfg_writes, phase);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
